/* hw/rtl/pwfr_pkg.sv */
// shared types, register indexes and reset values for the pulse width frame receiver
`timescale 1ns / 1ps
package pwfr_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [3:0]  BITS_PER_BYTE = 4'd8;
  localparam logic [7:0]  HIGH_TICKS_MAX = 8'hff;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZERO_MIN   = 3'd0,
    REG_ONE_MIN    = 3'd1,
    REG_LOW_WRAP   = 3'd2,
    REG_IDLE_RESET = 3'd3,
    REG_HEADER     = 3'd4,
    REG_ADDRESS    = 3'd5,
    REG_DISARM     = 3'd6
  } cfg_reg_t;

  // frame progress
  typedef enum logic [1:0] {
    FRAME_HEADER  = 2'd0,
    FRAME_ADDRESS = 2'd1,
    FRAME_COMMAND = 2'd2,
    FRAME_INVALID = 2'd3
  } frame_pos_t;

  // reset values of the registers
  localparam logic [7:0] ZERO_MIN_RESET   = 8'd35;
  localparam logic [7:0] ONE_MIN_RESET    = 8'd50;
  localparam logic [7:0] LOW_WRAP_RESET   = 8'd80;
  localparam logic [7:0] IDLE_RESET_RESET = 8'd60;

  typedef struct packed {
    logic [7:0] zero_min_ticks;
    logic [7:0] one_min_ticks;
    logic [7:0] low_wrap_ticks;
    logic [7:0] idle_reset_ticks;
    logic [7:0] frame_header;
    logic [7:0] own_address;
    logic [7:0] disarm_code;
  } cfg_t;

  typedef struct packed {
    logic [7:0] low_ticks;
    logic       line_was_high;
    logic [7:0] high_ticks;
    logic [7:0] shift_byte;
    logic [3:0] bit_index;
    frame_pos_t frame_position;
  } rx_state_t;

  typedef struct packed {
    logic       byte_done;
    logic [7:0] byte_value;
    logic       frame_done;
    logic [7:0] frame_command;
    logic       disarm;
    logic       idle_cleared;
  } rx_result_t;

endpackage

/* hw/rtl/pwfr_if.sv */
// valid/ready channel interfaces for line samples and receive results
`timescale 1ns / 1ps

interface pwfr_in_if;
  logic valid;
  logic ready;
  logic line_level;

  modport source (output valid, output line_level, input ready);
  modport sink (input valid, input line_level, output ready);
endinterface

interface pwfr_out_if;
  logic       valid;
  logic       ready;
  logic       byte_done;
  logic [7:0] byte_value;
  logic       frame_done;
  logic [7:0] frame_command;
  logic       disarm;
  logic       idle_cleared;

  modport source (output valid, output byte_done, output byte_value, output frame_done,
                  output frame_command, output disarm, output idle_cleared, input ready);
  modport sink (input valid, input byte_done, input byte_value, input frame_done,
                input frame_command, input disarm, input idle_cleared, output ready);
endinterface

/* hw/rtl/pulse_width_frame_receiver_core.sv */
// top level of the pulse width frame receiver: config registers, state and result register
`timescale 1ns / 1ps
// Pulse width frame receiver.
// in_ch carries one sampled level of the receive wire per word; out_ch returns exactly
// one result word per sample: byte_done/byte_value, frame_done/frame_command, disarm
// and idle_cleared. Low pulses are timed, classified on the rising edge into bit 0,
// bit 1 or ignored, shifted MSB first into bytes, and bytes are matched as header,
// own address and command.
// Latency: the result of a sample is on out_ch the cycle after it is accepted.
// Throughput: one sample per cycle; the receiver state updates from one compare/increment
// stage between the state registers and the result register.
// in_ch.ready stays high while the result register is empty or is being taken, so a
// new sample enters in the same cycle a waiting result leaves. When the receiver of
// out_ch stalls, the held result stays put, in_ch.ready drops and the offered sample
// waits until the held result is taken.
// cfg_we writes register cfg_index with cfg_data (0 zero_min_ticks .. 6 disarm_code);
// write only while no sample is in flight. Indexes past the list are ignored.
// Reset (rst_n low, synchronous) restores the register defaults, clears the counters,
// bit and frame progress, and empties the result register.
module pulse_width_frame_receiver_core
  import pwfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pwfr_in_if.sink               in_ch,
  pwfr_out_if.source            out_ch
);

  cfg_t       cfg_r;
  rx_state_t  state_r;
  rx_state_t  state_nxt;
  rx_result_t step_res;
  rx_result_t res_r;
  logic       out_valid_r;
  logic       take_word;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero_min_ticks   <= ZERO_MIN_RESET;
      cfg_r.one_min_ticks    <= ONE_MIN_RESET;
      cfg_r.low_wrap_ticks   <= LOW_WRAP_RESET;
      cfg_r.idle_reset_ticks <= IDLE_RESET_RESET;
      cfg_r.frame_header     <= 8'd0;
      cfg_r.own_address      <= 8'd0;
      cfg_r.disarm_code      <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ZERO_MIN:   cfg_r.zero_min_ticks   <= cfg_data;
        REG_ONE_MIN:    cfg_r.one_min_ticks    <= cfg_data;
        REG_LOW_WRAP:   cfg_r.low_wrap_ticks   <= cfg_data;
        REG_IDLE_RESET: cfg_r.idle_reset_ticks <= cfg_data;
        REG_HEADER:     cfg_r.frame_header     <= cfg_data;
        REG_ADDRESS:    cfg_r.own_address      <= cfg_data;
        REG_DISARM:     cfg_r.disarm_code      <= cfg_data;
        default: ;
      endcase
    end
  end

  // accept when the result register is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign take_word   = in_ch.valid && in_ch.ready;

  pwfr_step u_step (
    .cfg        (cfg_r),
    .cur        (state_r),
    .line_level (in_ch.line_level),
    .nxt        (state_nxt),
    .res        (step_res)
  );

  // receiver state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.low_ticks      <= 8'd0;
      state_r.line_was_high  <= 1'b1;
      state_r.high_ticks     <= 8'd0;
      state_r.shift_byte     <= 8'd0;
      state_r.bit_index      <= 4'd0;
      state_r.frame_position <= FRAME_HEADER;
    end else if (take_word) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take_word) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_word) begin
      res_r <= step_res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.byte_done     = res_r.byte_done;
  assign out_ch.byte_value    = res_r.byte_value;
  assign out_ch.frame_done    = res_r.frame_done;
  assign out_ch.frame_command = res_r.frame_command;
  assign out_ch.disarm        = res_r.disarm;
  assign out_ch.idle_cleared  = res_r.idle_cleared;

  // bit counter never holds a full byte between samples
  a_bit_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.bit_index < BITS_PER_BYTE)
    else $error("bit index left at or above a full byte");

  // a frame ends only on a completed byte
  a_frame_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.frame_done |-> res_r.byte_done)
    else $error("frame done without byte done");

  // disarm only on a completed frame
  a_disarm_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.disarm |-> res_r.frame_done)
    else $error("disarm without frame done");

  // idle clear drops bit progress so no byte can finish in the same sample
  a_idle_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.idle_cleared |-> !res_r.byte_done)
    else $error("byte done together with idle clear");

  // an accepted sample always lands in the result register
  a_take_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    take_word |=> out_valid_r)
    else $error("accepted sample produced no result");

endmodule

/* hw/rtl/pwfr_step.sv */
// next state and result for one line sample: pulse timing, bit shift and frame match
`timescale 1ns / 1ps
module pwfr_step
  import pwfr_pkg::*;
(
  input  cfg_t       cfg,
  input  rx_state_t  cur,
  input  logic       line_level,
  output rx_state_t  nxt,
  output rx_result_t res
);

  logic [7:0] low_inc;
  logic [7:0] high_bump;
  logic       is_zero;
  logic       is_one;
  logic       idle_hit;
  rx_state_t  mid;

  assign low_inc   = cur.low_ticks + 8'd1;
  assign high_bump = (cur.high_ticks == HIGH_TICKS_MAX) ? HIGH_TICKS_MAX
                                                        : cur.high_ticks + 8'd1;
  assign is_one    = cur.low_ticks > cfg.one_min_ticks;
  assign is_zero   = (cur.low_ticks > cfg.zero_min_ticks) &&
                     (cur.low_ticks <= cfg.one_min_ticks);

  // pulse timing and bit decode
  always_comb begin
    mid              = cur;
    idle_hit         = 1'b0;
    if (!line_level) begin
      mid.line_was_high = 1'b0;
      mid.low_ticks     = (low_inc == cfg.low_wrap_ticks) ? 8'd0 : low_inc;
    end else if (!cur.line_was_high) begin
      // rising edge closes the low pulse
      mid.line_was_high = 1'b1;
      mid.low_ticks     = 8'd0;
      if (is_zero || is_one) begin
        mid.shift_byte = {cur.shift_byte[6:0], is_one};
        mid.bit_index  = cur.bit_index + 4'd1;
        mid.high_ticks = 8'd0;
      end else begin
        mid.high_ticks = high_bump;
      end
    end else begin
      mid.high_ticks = high_bump;
      if (high_bump >= cfg.idle_reset_ticks) begin
        mid.bit_index      = 4'd0;
        mid.frame_position = FRAME_HEADER;
        idle_hit           = 1'b1;
      end
    end
  end

  // byte completion and frame match
  always_comb begin
    nxt              = mid;
    res              = '0;
    res.idle_cleared = idle_hit;
    if (mid.bit_index == BITS_PER_BYTE) begin
      nxt.bit_index  = 4'd0;
      res.byte_done  = 1'b1;
      res.byte_value = mid.shift_byte;
      if (mid.frame_position == FRAME_HEADER && mid.shift_byte == cfg.frame_header) begin
        nxt.frame_position = FRAME_ADDRESS;
      end else if (mid.frame_position == FRAME_ADDRESS &&
                   mid.shift_byte == cfg.own_address) begin
        nxt.frame_position = FRAME_COMMAND;
      end else if (mid.frame_position == FRAME_COMMAND) begin
        nxt.frame_position = FRAME_HEADER;
        res.frame_done     = 1'b1;
        res.frame_command  = mid.shift_byte;
        res.disarm         = (mid.shift_byte == cfg.disarm_code);
      end else begin
        nxt.frame_position = FRAME_HEADER;
      end
    end
  end

endmodule

/* dv/tb.sv */
// testbench for the pulse width frame receiver core
`timescale 1ns / 1ps

module tb;
  import pwfr_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT   = 2000;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int unsigned PHASE_SAMPLES    = 40;
  localparam int unsigned RANDOM_PHASES    = 2;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pwfr_in_if  in_ch ();
  pwfr_out_if out_ch ();

  pulse_width_frame_receiver_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #2 clk = ~clk;

  // decoder copy: registers and receive state
  cfg_t        rx_cfg;
  rx_state_t   rx_st;
  rx_result_t  pending_rx_results[$];

  int unsigned samples_taken = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  bit          idling_on = 1'b1;
  bit          hold_off_req = 1'b0;

  // one line sample through the decoder, returns the result word it causes
  function automatic rx_result_t decode_sample(input logic level);
    rx_result_t r;
    r = '0;
    if (!level) begin
      rx_st.low_ticks = rx_st.low_ticks + 8'd1;
      rx_st.line_was_high = 1'b0;
      if (rx_st.low_ticks == rx_cfg.low_wrap_ticks) rx_st.low_ticks = 8'd0;
    end else if (!rx_st.line_was_high) begin
      // rising edge: classify the low pulse
      rx_st.line_was_high = 1'b1;
      if (rx_st.low_ticks > rx_cfg.zero_min_ticks &&
          rx_st.low_ticks <= rx_cfg.one_min_ticks) begin
        rx_st.shift_byte = {rx_st.shift_byte[6:0], 1'b0};
        rx_st.bit_index = rx_st.bit_index + 4'd1;
        rx_st.high_ticks = 8'd0;
      end else if (rx_st.low_ticks > rx_cfg.one_min_ticks) begin
        rx_st.shift_byte = {rx_st.shift_byte[6:0], 1'b1};
        rx_st.bit_index = rx_st.bit_index + 4'd1;
        rx_st.high_ticks = 8'd0;
      end else if (rx_st.high_ticks != HIGH_TICKS_MAX) begin
        rx_st.high_ticks = rx_st.high_ticks + 8'd1;
      end
      rx_st.low_ticks = 8'd0;
    end else begin
      // high idle, saturating count
      if (rx_st.high_ticks != HIGH_TICKS_MAX) rx_st.high_ticks = rx_st.high_ticks + 8'd1;
      if (rx_st.high_ticks >= rx_cfg.idle_reset_ticks) begin
        rx_st.bit_index = 4'd0;
        rx_st.frame_position = FRAME_HEADER;
        r.idle_cleared = 1'b1;
      end
    end

    // byte complete: frame matching
    if (rx_st.bit_index == BITS_PER_BYTE) begin
      rx_st.bit_index = 4'd0;
      r.byte_done = 1'b1;
      r.byte_value = rx_st.shift_byte;
      if (rx_st.frame_position == FRAME_HEADER && rx_st.shift_byte == rx_cfg.frame_header) begin
        rx_st.frame_position = FRAME_ADDRESS;
      end else if (rx_st.frame_position == FRAME_ADDRESS &&
                   rx_st.shift_byte == rx_cfg.own_address) begin
        rx_st.frame_position = FRAME_COMMAND;
      end else if (rx_st.frame_position == FRAME_COMMAND) begin
        rx_st.frame_position = FRAME_HEADER;
        r.frame_done = 1'b1;
        r.frame_command = rx_st.shift_byte;
        r.disarm = (rx_st.shift_byte == rx_cfg.disarm_code);
      end else begin
        rx_st.frame_position = FRAME_HEADER;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  // result check, sample capture, register tracking and watchdog
  always @(posedge clk) begin : rx_monitor
    rx_result_t want;
    bit moved;
    if (!rst_n) begin
      rx_cfg = '{zero_min_ticks: ZERO_MIN_RESET, one_min_ticks: ONE_MIN_RESET,
                 low_wrap_ticks: LOW_WRAP_RESET, idle_reset_ticks: IDLE_RESET_RESET,
                 frame_header: 8'd0, own_address: 8'd0, disarm_code: 8'd0};
      rx_st = '{low_ticks: 8'd0, line_was_high: 1'b1, high_ticks: 8'd0,
                shift_byte: 8'd0, bit_index: 4'd0, frame_position: FRAME_HEADER};
      pending_rx_results.delete();
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (pending_rx_results.size() == 0) begin
          $error("result word with no sample waiting for it");
          fail_count++;
        end else begin
          want = pending_rx_results.pop_front();
          check_field("byte_done", 32'(want.byte_done), 32'(out_ch.byte_done));
          check_field("byte_value", 32'(want.byte_value), 32'(out_ch.byte_value));
          check_field("frame_done", 32'(want.frame_done), 32'(out_ch.frame_done));
          check_field("frame_command", 32'(want.frame_command),
                      32'(out_ch.frame_command));
          check_field("disarm", 32'(want.disarm), 32'(out_ch.disarm));
          check_field("idle_cleared", 32'(want.idle_cleared), 32'(out_ch.idle_cleared));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        pending_rx_results.push_back(decode_sample(in_ch.line_level));
        samples_taken++;
      end
      if (cfg_we) begin
        moved = 1'b1;
        case (cfg_reg_t'(cfg_index))
          REG_ZERO_MIN:   rx_cfg.zero_min_ticks = cfg_data;
          REG_ONE_MIN:    rx_cfg.one_min_ticks = cfg_data;
          REG_LOW_WRAP:   rx_cfg.low_wrap_ticks = cfg_data;
          REG_IDLE_RESET: rx_cfg.idle_reset_ticks = cfg_data;
          REG_HEADER:     rx_cfg.frame_header = cfg_data;
          REG_ADDRESS:    rx_cfg.own_address = cfg_data;
          REG_DISARM:     rx_cfg.disarm_code = cfg_data;
          default: ;
        endcase
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // result side: random stall bursts and the long hold-off
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready = 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = rst_n;
      end
    end
  end

  // one sample word, called at a falling edge, returns at the falling edge after acceptance
  task automatic send_sample(input logic level);
    int unsigned target;
    if (idling_on && $urandom_range(0, 11) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    target = samples_taken + 1;
    in_ch.valid = 1'b1;
    in_ch.line_level = level;
    do @(negedge clk); while (samples_taken != target);
  endtask

  task automatic send_pulse(input int unsigned low_len, input int unsigned high_len);
    repeat (low_len) send_sample(1'b0);
    repeat (high_len) send_sample(1'b1);
  endtask

  // well-formed bit with random timing inside the current thresholds
  task automatic send_bit(input logic b);
    int unsigned lo_max;
    int unsigned low_len;
    lo_max = (rx_cfg.low_wrap_ticks == 8'd0) ? 255 : rx_cfg.low_wrap_ticks - 1;
    if (b) low_len = $urandom_range(rx_cfg.one_min_ticks + 1, lo_max);
    else low_len = $urandom_range(rx_cfg.zero_min_ticks + 1, rx_cfg.one_min_ticks);
    send_pulse(low_len, $urandom_range(1, rx_cfg.idle_reset_ticks));
  endtask

  task automatic send_byte(input logic [7:0] b);
    for (int i = 7; i >= 0; i--) send_bit(b[i]);
  endtask

  task automatic send_idle_clear();
    send_pulse(0, rx_cfg.idle_reset_ticks + $urandom_range(1, 3));
  endtask

  task automatic send_frame(input logic [7:0] cmd);
    send_byte(rx_cfg.frame_header);
    send_byte(rx_cfg.own_address);
    send_byte(cmd);
    send_idle_clear();
  endtask

  // stop offering samples and let every result come back
  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending_rx_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] zero_min, input logic [7:0] one_min,
                            input logic [7:0] low_wrap, input logic [7:0] idle_reset,
                            input logic [7:0] header, input logic [7:0] address,
                            input logic [7:0] disarm_code);
    logic [7:0] vals [7];
    vals = '{zero_min, one_min, low_wrap, idle_reset, header, address, disarm_code};
    drain();
    for (int i = 0; i < 7; i++) begin
      cfg_we = 1'b1;
      cfg_index = CFG_IDX_W'(i);
      cfg_data = vals[i];
      @(negedge clk);
    end
    cfg_we = 1'b0;
  endtask

  task automatic set_small_config();
    logic [7:0] z;
    logic [7:0] o;
    z = 8'($urandom_range(0, 3));
    o = z + 8'($urandom_range(1, 4));
    set_config(z, o, o + 8'($urandom_range(2, 6)), 8'($urandom_range(2, 8)),
               8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // reset thresholds: pulse length boundaries, wrap, idle clear
  task automatic test_default_thresholds();
    send_pulse(35, 3);
    send_pulse(36, 3);
    send_pulse(50, 3);
    send_pulse(51, 3);
    send_pulse(10, 3);
    send_pulse(100, 3);
    send_idle_clear();
  endtask

  // header and address match, wrong bytes, idle clear in the middle of a byte
  task automatic test_frame_matching();
    set_config(8'd1, 8'd2, 8'd4, 8'd2, 8'ha5, 8'h3c, 8'hff);
    send_frame(8'hff);
    send_byte(8'h5a);
    send_byte(8'h3c);
    send_byte(8'hff);
    send_idle_clear();
    send_byte(8'ha5);
    send_byte(8'h3d);
    send_byte(8'hff);
    send_idle_clear();
    repeat (5) send_bit(1'b1);
    send_idle_clear();
    send_pulse(1, 2);
    send_frame(8'h81);
  endtask

  // threshold corners: all ones, no bits at all, overlap, tiny wrap, saturation
  task automatic test_threshold_extremes();
    set_config(8'd0, 8'd0, 8'd255, 8'd255, 8'hff, 8'hff, 8'hff);
    repeat (24) send_pulse($urandom_range(1, 4), $urandom_range(1, 3));
    send_pulse(0, 260);
    set_config(8'd255, 8'd255, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00);
    send_pulse(256, 2);
    send_pulse(3, 3);
    set_config(8'd6, 8'd3, 8'd10, 8'd4, 8'hff, 8'h00, 8'h55);
    repeat (12) send_pulse($urandom_range(0, 12), $urandom_range(1, 5));
    set_config(8'd0, 8'd0, 8'd1, 8'd3, 8'h00, 8'h00, 8'h00);
    repeat (6) send_pulse($urandom_range(1, 5), $urandom_range(1, 4));
  endtask

  // result side held off while the sender keeps offering samples
  task automatic test_output_stall();
    set_small_config();
    idling_on = 1'b0;
    hold_off_req = 1'b1;
    send_frame(8'($urandom));
    idling_on = 1'b1;
  endtask

  // random configurations, mostly well-formed frames with random content
  task automatic test_random_traffic();
    int unsigned start;
    int unsigned pick;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_small_config();
      idling_on = (p == RANDOM_PHASES - 1) ? 1'b0 : (p != 2);
      start = samples_taken;
      while (samples_taken - start < PHASE_SAMPLES) begin
        pick = $urandom_range(0, 9);
        if (pick <= 6) begin
          send_frame(($urandom_range(0, 2) == 0) ? rx_cfg.disarm_code : 8'($urandom));
        end else if (pick == 7) begin
          // address with one bit flipped, header with one bit flipped in about half the cases
          send_byte(rx_cfg.frame_header ^ (($urandom_range(0, 1) == 0) ? 8'd0 :
                    8'(1 << $urandom_range(0, 7))));
          send_byte(rx_cfg.own_address ^ 8'(1 << $urandom_range(0, 7)));
          send_byte(8'($urandom));
          send_idle_clear();
        end else if (pick == 8) begin
          repeat ($urandom_range(1, 7)) send_bit(1'($urandom_range(0, 1)));
          send_idle_clear();
        end else begin
          repeat ($urandom_range(1, 6))
            send_pulse($urandom_range(0, rx_cfg.low_wrap_ticks + 2),
                       $urandom_range(1, rx_cfg.idle_reset_ticks + 2));
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_ZERO_MIN;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.line_level = 1'b1;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_default_thresholds();
    test_frame_matching();
    test_threshold_extremes();
    test_output_stall();
    test_random_traffic();

    drain();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
